FILE: sv/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared constants, codes and controller/datapath interface types for the
// countdown timer table.
// ----------------------------------------------------------------------------
package ctt_pkg;

  // Table geometry
  localparam int SLOTS       = 32;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Field widths
  localparam int MODE_W = 2;
  localparam int ID_W   = 16;
  localparam int SEC_W  = 16;
  localparam int RES_W  = 3;
  localparam int ENTRY_W = ID_W + SEC_W;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd3;

  // Result codes
  localparam logic [RES_W-1:0] EV_STARTED     = 3'd0;
  localparam logic [RES_W-1:0] EV_FULL        = 3'd1;
  localparam logic [RES_W-1:0] EV_CANCELLED   = 3'd2;
  localparam logic [RES_W-1:0] EV_CANCEL_MISS = 3'd3;
  localparam logic [RES_W-1:0] EV_QUERY       = 3'd4;
  localparam logic [RES_W-1:0] EV_QUERY_MISS  = 3'd5;
  localparam logic [RES_W-1:0] EV_EXPIRED     = 3'd6;

  // Which result the datapath loads into the output register
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_PEND_MID,   // held expiry, more may follow
    EMIT_PEND_LAST,  // held expiry, final one of the tick
    EMIT_REQ_HIT,    // request found its slot
    EMIT_REQ_MISS    // request scanned the whole table without a match
  } ctt_emit_t;

  // Controller to datapath
  typedef struct packed {
    logic      accept;   // latch the input transaction, restart the scan
    logic      rd_en;    // read the table entry at the scan index
    logic      commit;   // apply the slot action at the scan index
    logic      advance;  // step the scan index
    ctt_emit_t emit;
  } ctt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
    logic hit;
    logic pend_valid;
    logic last_slot;
    logic out_free;
  } ctt_stat_t;

endpackage

FILE: sv/ctt_ram.sv
// ----------------------------------------------------------------------------
// ctt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/ctt_ctrl.sv
// ----------------------------------------------------------------------------
// ctt_ctrl
// Scan sequencer: accepts a transaction, walks the slots one read/evaluate
// pair at a time and decides when results are pushed to the output register.
// ----------------------------------------------------------------------------
module ctt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ctt_pkg::ctt_stat_t stat,
  output ctt_pkg::ctt_cmd_t  cmd
);
  import ctt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit  = EMIT_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        if (stat.is_tick) begin
          // an expiry pushes out the previously held one first
          if (!(stat.hit && stat.pend_valid && !stat.out_free)) begin
            cmd.commit = 1'b1;
            if (stat.hit && stat.pend_valid) begin
              cmd.emit = EMIT_PEND_MID;
            end
            if (stat.last_slot) begin
              state_nxt = S_FIN;
            end else begin
              cmd.advance = 1'b1;
              state_nxt   = S_RD;
            end
          end
        end else if (stat.hit) begin
          if (stat.out_free) begin
            cmd.commit = 1'b1;
            cmd.emit   = EMIT_REQ_HIT;
            state_nxt  = S_IDLE;
          end
        end else if (stat.last_slot) begin
          state_nxt = S_FIN;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_FIN: begin
        if (stat.is_tick) begin
          if (!stat.pend_valid) begin
            state_nxt = S_IDLE;
          end else if (stat.out_free) begin
            cmd.emit  = EMIT_PEND_LAST;
            state_nxt = S_IDLE;
          end
        end else if (stat.out_free) begin
          cmd.emit  = EMIT_REQ_MISS;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

FILE: sv/ctt_dp.sv
// ----------------------------------------------------------------------------
// ctt_dp
// Timer table datapath: active bits, identifier/count RAM, scan index,
// held expiry, expiry counter and the output register.
// ----------------------------------------------------------------------------
module ctt_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [ctt_pkg::MODE_W-1:0]      in_mode,
  input  logic [ctt_pkg::ID_W-1:0]        in_timer_id,
  input  logic [ctt_pkg::SEC_W-1:0]       in_duration,
  input  ctt_pkg::ctt_cmd_t               cmd,
  output ctt_pkg::ctt_stat_t              stat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ctt_pkg::RES_W-1:0]       out_event_res,
  output logic [ctt_pkg::ID_W-1:0]        out_event_id,
  output logic [ctt_pkg::SEC_W-1:0]       out_seconds_left,
  output logic                            out_last
);
  import ctt_pkg::*;

  // request latch
  logic [MODE_W-1:0] mode_r;
  logic [ID_W-1:0]   id_r;
  logic [SEC_W-1:0]  dur_r;

  // scan and table state
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [SLOTS-1:0]  act_r, act_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]  res_r, res_nxt;
  logic [ID_W-1:0]   oid_r, oid_nxt;
  logic [SEC_W-1:0]  secs_r, secs_nxt;
  logic              last_r, last_nxt;

  // table RAM
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  logic [ID_W-1:0]    rd_ident;
  logic [SEC_W-1:0]   rd_rem;
  logic [SEC_W-1:0]   dec;
  logic               cur_act;
  logic               is_tick;
  logic               hit;
  logic               out_free;

  ctt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  assign rd_ident = rd_data[ENTRY_W-1:SEC_W];
  assign rd_rem   = rd_data[SEC_W-1:0];
  assign dec      = (rd_rem == '0) ? '0 : rd_rem - SEC_W'(1);
  assign cur_act  = act_r[idx_r];
  assign is_tick  = (mode_r == MODE_TICK);
  assign out_free = !out_valid_r || !out_stall;

  // does the slot under the scan index take this transaction's action
  always_comb begin
    unique case (mode_r) inside
      MODE_TICK:               hit = cur_act && (dec == '0) && (n_r < CNT_W'(MAX_RESULTS));
      MODE_START:              hit = !cur_act;
      MODE_CANCEL, MODE_QUERY: hit = cur_act && (rd_ident == id_r);
      default:                 hit = 1'b0;
    endcase
  end

  assign stat.is_tick    = is_tick;
  assign stat.hit        = hit;
  assign stat.pend_valid = pend_valid_r;
  assign stat.last_slot  = (idx_r == IDX_W'(SLOTS - 1));
  assign stat.out_free   = out_free;

  // slot update on commit
  always_comb begin
    wr_en          = 1'b0;
    wr_data        = {rd_ident, dec};
    act_nxt        = act_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    n_nxt          = n_r;
    if (cmd.accept) begin
      pend_valid_nxt = 1'b0;
      n_nxt          = '0;
    end else if (cmd.commit) begin
      unique case (mode_r)
        MODE_TICK: begin
          wr_en = cur_act;
          if (hit) begin
            act_nxt[idx_r] = 1'b0;
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = rd_ident;
            n_nxt          = n_r + CNT_W'(1);
          end
        end
        MODE_START: begin
          wr_en          = 1'b1;
          wr_data        = {id_r, dur_r};
          act_nxt[idx_r] = 1'b1;
        end
        MODE_CANCEL: begin
          act_nxt[idx_r] = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // scan index
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.accept) begin
      idx_nxt = '0;
    end else if (cmd.advance) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  // output register load
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    oid_nxt       = oid_r;
    secs_nxt      = secs_r;
    last_nxt      = last_r;
    case (cmd.emit) inside
      EMIT_PEND_MID, EMIT_PEND_LAST: begin
        out_valid_nxt = 1'b1;
        res_nxt       = EV_EXPIRED;
        oid_nxt       = pend_id_r;
        secs_nxt      = '0;
        last_nxt      = (cmd.emit == EMIT_PEND_LAST);
      end
      EMIT_REQ_HIT: begin
        out_valid_nxt = 1'b1;
        oid_nxt       = id_r;
        secs_nxt      = '0;
        last_nxt      = 1'b1;
        unique case (mode_r) inside
          MODE_START:  res_nxt = EV_STARTED;
          MODE_CANCEL: res_nxt = EV_CANCELLED;
          default: begin
            res_nxt  = EV_QUERY;
            secs_nxt = rd_rem;
          end
        endcase
      end
      EMIT_REQ_MISS: begin
        out_valid_nxt = 1'b1;
        oid_nxt       = id_r;
        secs_nxt      = '0;
        last_nxt      = 1'b1;
        unique case (mode_r) inside
          MODE_START:  res_nxt = EV_FULL;
          MODE_CANCEL: res_nxt = EV_CANCEL_MISS;
          default:     res_nxt = EV_QUERY_MISS;
        endcase
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r        <= '0;
      pend_valid_r <= 1'b0;
      n_r          <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      act_r        <= act_nxt;
      pend_valid_r <= pend_valid_nxt;
      n_r          <= n_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      id_r   <= in_timer_id;
      dur_r  <= in_duration;
    end
    pend_id_r <= pend_id_nxt;
    res_r     <= res_nxt;
    oid_r     <= oid_nxt;
    secs_r    <= secs_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = res_r;
  assign out_event_id     = oid_r;
  assign out_seconds_left = secs_r;
  assign out_last         = last_r;

  // a result is only loaded when the output register can take it
  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit != EMIT_NONE) |-> out_free)
    else $error("result loaded into a full output register");

  // expiries per tick stay within the result limit
  a_expiry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_RESULTS))
    else $error("expiry count over limit");

  // a new expiry on top of a held one must push the held one out
  a_pend_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && is_tick && hit && pend_valid_r) |-> (cmd.emit == EMIT_PEND_MID))
    else $error("held expiry overwritten");

  // the scan never steps past the last slot
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |=> (idx_r != '0))
    else $error("scan index wrapped");

endmodule

FILE: sv/countdown_timer_table_core.sv
// ----------------------------------------------------------------------------
// countdown_timer_table_core
// Fixed table of countdown timer slots with start, cancel, query and tick.
// ----------------------------------------------------------------------------
// Each transaction walks the slot table in order, a read state then an
// evaluate state per slot, because the identifier/count table sits in a
// single-write, single-read RAM with a registered read. A tick always visits
// all SLOTS slots, issuing one expired result per slot that reaches zero, in
// slot order, with last set on the final one; a tick without expiries gives
// no result. Start, cancel and query stop at the first slot that fits (start:
// first free slot, cancel/query: first active slot with the same identifier)
// and give exactly one result with last set; a miss scans the whole table.
// A stalled output holds the scan until the result can be loaded. The active
// bits clear at reset, so no clearing pass is needed, and a new transaction is
// taken only when the previous one has finished its scan.
// ----------------------------------------------------------------------------
module countdown_timer_table_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ctt_pkg::MODE_W-1:0]  in_mode,
  input  logic [ctt_pkg::ID_W-1:0]    in_timer_id,
  input  logic [ctt_pkg::SEC_W-1:0]   in_duration,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ctt_pkg::RES_W-1:0]   out_event_res,
  output logic [ctt_pkg::ID_W-1:0]    out_event_id,
  output logic [ctt_pkg::SEC_W-1:0]   out_seconds_left,
  output logic                        out_last
);
  import ctt_pkg::*;

  ctt_cmd_t  cmd;
  ctt_stat_t stat;

  // scan sequencer
  ctt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table and result datapath
  ctt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mode          (in_mode),
    .in_timer_id      (in_timer_id),
    .in_duration      (in_duration),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_event_id     (out_event_id),
    .out_seconds_left (out_seconds_left),
    .out_last         (out_last)
  );

endmodule
